// ===== hw/rtl/lbp_pkg.sv =====
// Shared types, constants and elaboration-time mapping tables for the LBP code block.
package lbp_pkg;

    localparam int DEF_NEIGHBOURS  = 8;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int FIELD_BITS      = 16;
    localparam int CODE_BITS       = 8;
    localparam int LUT_DEPTH       = 256;

    typedef enum logic [1:0] {
        STYLE_RAW     = 2'd0,
        STYLE_UNIFORM = 2'd1,
        STYLE_ROT     = 2'd2,
        STYLE_RIU2    = 2'd3
    } style_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] center_sample;
        logic [FIELD_BITS-1:0] neighbour_0;
        logic [FIELD_BITS-1:0] neighbour_1;
        logic [FIELD_BITS-1:0] neighbour_2;
        logic [FIELD_BITS-1:0] neighbour_3;
        logic [FIELD_BITS-1:0] neighbour_4;
        logic [FIELD_BITS-1:0] neighbour_5;
        logic [FIELD_BITS-1:0] neighbour_6;
        logic [FIELD_BITS-1:0] neighbour_7;
    } lbp_in_t;

    typedef struct packed {
        logic [7:0] raw_code;
        logic [7:0] mapped_bin;
        logic [8:0] bin_total;
    } lbp_out_t;

    typedef logic [7:0] bin_lut_t [LUT_DEPTH];

    // Circular left rotate over p bits
    function automatic int rot_left(input int v, input int p);
        int mask;
        int r;
        mask = (1 << p) - 1;
        r = v & mask;
        return ((r << 1) | (r >> (p - 1))) & mask;
    endfunction

    function automatic int ones_count(input int v);
        int n;
        n = 0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + ((v >> i) & 1);
        end
        return n;
    endfunction

    // At most two circular 0/1 transitions
    function automatic bit is_uniform(input int v, input int p);
        return ones_count(v ^ rot_left(v, p)) <= 2;
    endfunction

    function automatic int min_rotation(input int v, input int p);
        int r;
        int m;
        r = v & ((1 << p) - 1);
        m = r;
        for (int j = 1; j < p; j++)
        begin
            r = rot_left(r, p);
            if (r < m)
                m = r;
        end
        return m;
    endfunction

    // Bin of every code under one style; codes at or above 2^p never occur
    function automatic bin_lut_t build_lut(input int p, input style_t style);
        bin_lut_t lut;
        int       below [LUT_DEPTH + 1];
        int       cnt;
        int       val;
        // Running count of class representatives (rotation style)
        below[0] = 0;
        for (int c = 0; c < LUT_DEPTH; c++)
        begin
            below[c + 1] = below[c] + ((c < (1 << p) && min_rotation(c, p) == c) ? 1 : 0);
        end
        cnt = 0;
        for (int c = 0; c < LUT_DEPTH; c++)
        begin
            val = 0;
            if (c < (1 << p))
            begin
                case (style)
                    STYLE_RAW:     val = c;
                    STYLE_UNIFORM:
                    begin
                        if (is_uniform(c, p))
                        begin
                            val = cnt;
                            cnt = cnt + 1;
                        end
                        else
                            val = p * (p - 1) + 2;
                    end
                    STYLE_ROT:     val = below[min_rotation(c, p)];
                    default:       val = is_uniform(c, p) ? ones_count(c) : p + 1;
                endcase
            end
            lut[c] = 8'(val);
        end
        return lut;
    endfunction

    // Number of bins a style produces for p neighbours
    function automatic logic [8:0] bin_count(input int p, input style_t style);
        int n;
        n = 0;
        case (style)
            STYLE_RAW:     n = 1 << p;
            STYLE_UNIFORM: n = p * (p - 1) + 3;
            STYLE_ROT:
            begin
                for (int c = 0; c < (1 << p); c++)
                begin
                    if (min_rotation(c, p) == c)
                        n = n + 1;
                end
            end
            default:       n = p + 2;
        endcase
        return 9'(n);
    endfunction

endpackage

// ===== hw/rtl/lbp_code_with_pattern_mapping.sv =====
// Top level: style register, compare and map stages, output register.
//
//   channel | signals                        | direction
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data    | center and neighbour samples
//   out     | out_valid, out_ready, out_data | raw code, bin, bin count
//   cfg     | cfg_valid, cfg_ready, cfg_data | pattern style write
//
// One request per cycle while out_ready holds, through three register stages
// (compare, table lookup, output register); a result is offered once it has
// passed the compare and lookup registers into the output register.
// Reset empties all three stages and sets the style to rotation invariant.
// Each stage holds its request while the next is full and blocked; ready
// back to the input is the chained stage ready.
module lbp_code_with_pattern_mapping #(
    parameter int NEIGHBOURS  = lbp_pkg::DEF_NEIGHBOURS,
    parameter int SAMPLE_BITS = lbp_pkg::DEF_SAMPLE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lbp_pkg::lbp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lbp_pkg::lbp_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);
    import lbp_pkg::*;

    style_t               style_reg;
    logic                 code_valid;
    logic                 code_ready;
    logic [CODE_BITS-1:0] code;
    logic                 map_valid;
    logic                 map_ready;
    lbp_out_t             map_data;
    logic                 out_valid_reg;
    lbp_out_t             out_reg;

    // Style register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            style_reg <= STYLE_ROT;
        else if (cfg_valid)
            style_reg <= style_t'(cfg_data);
    end

    lbp_compare #(
        .NEIGHBOURS  (NEIGHBOURS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

    lbp_map #(
        .NEIGHBOURS (NEIGHBOURS)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .style      (style_reg),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code),
        .map_valid  (map_valid),
        .map_ready  (map_ready),
        .map_data   (map_data)
    );

    // Output register
    assign map_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (map_ready)
            out_valid_reg <= map_valid;
    end

    always_ff @(posedge clk)
    begin
        if (map_valid && map_ready)
            out_reg <= map_data;
    end

endmodule

// ===== hw/rtl/lbp_compare.sv =====
// Stage 1: neighbour versus center comparison into the raw code.
module lbp_compare #(
    parameter int NEIGHBOURS  = lbp_pkg::DEF_NEIGHBOURS,
    parameter int SAMPLE_BITS = lbp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lbp_pkg::lbp_in_t       in_data,
    output logic                   code_valid,
    input  logic                   code_ready,
    output logic [lbp_pkg::CODE_BITS-1:0] code
);
    import lbp_pkg::*;

    // Compare only the low sample bits that fit in a field
    localparam int CMP_BITS = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

    logic [CMP_BITS-1:0]  nb [CODE_BITS];
    logic [CMP_BITS-1:0]  ctr;
    logic [CODE_BITS-1:0] code_next;
    logic [CODE_BITS-1:0] code_reg;
    logic                 valid_reg;
    logic                 load;

    assign ctr   = in_data.center_sample[CMP_BITS-1:0];
    assign nb[0] = in_data.neighbour_0[CMP_BITS-1:0];
    assign nb[1] = in_data.neighbour_1[CMP_BITS-1:0];
    assign nb[2] = in_data.neighbour_2[CMP_BITS-1:0];
    assign nb[3] = in_data.neighbour_3[CMP_BITS-1:0];
    assign nb[4] = in_data.neighbour_4[CMP_BITS-1:0];
    assign nb[5] = in_data.neighbour_5[CMP_BITS-1:0];
    assign nb[6] = in_data.neighbour_6[CMP_BITS-1:0];
    assign nb[7] = in_data.neighbour_7[CMP_BITS-1:0];

    // Strictly greater sets the bit; unused neighbours stay clear
    always_comb
    begin
        for (int n = 0; n < CODE_BITS; n++)
        begin
            code_next[n] = (n < NEIGHBOURS) && (nb[n] > ctr);
        end
    end

    assign in_ready   = !valid_reg || code_ready;
    assign load       = in_valid && in_ready;
    assign code_valid = valid_reg;
    assign code       = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            code_reg <= code_next;
    end

endmodule

// ===== hw/rtl/lbp_map.sv =====
// Stage 2: table lookup of the bin and bin count for the selected style.
module lbp_map #(
    parameter int NEIGHBOURS = lbp_pkg::DEF_NEIGHBOURS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbp_pkg::style_t               style,
    input  logic                          code_valid,
    output logic                          code_ready,
    input  logic [lbp_pkg::CODE_BITS-1:0] code,
    output logic                          map_valid,
    input  logic                          map_ready,
    output lbp_pkg::lbp_out_t             map_data
);
    import lbp_pkg::*;

    localparam bin_lut_t   LUT_UNI  = build_lut(NEIGHBOURS, STYLE_UNIFORM);
    localparam bin_lut_t   LUT_ROT  = build_lut(NEIGHBOURS, STYLE_ROT);
    localparam bin_lut_t   LUT_RIU2 = build_lut(NEIGHBOURS, STYLE_RIU2);
    localparam logic [8:0] TOT_RAW  = bin_count(NEIGHBOURS, STYLE_RAW);
    localparam logic [8:0] TOT_UNI  = bin_count(NEIGHBOURS, STYLE_UNIFORM);
    localparam logic [8:0] TOT_ROT  = bin_count(NEIGHBOURS, STYLE_ROT);
    localparam logic [8:0] TOT_RIU2 = bin_count(NEIGHBOURS, STYLE_RIU2);

    lbp_out_t map_next;
    lbp_out_t map_reg;
    logic     valid_reg;
    logic     load;

    // Style select over the lookups
    always_comb
    begin
        map_next.raw_code = code;
        case (style)
            STYLE_RAW:
            begin
                map_next.mapped_bin = code;
                map_next.bin_total  = TOT_RAW;
            end
            STYLE_UNIFORM:
            begin
                map_next.mapped_bin = LUT_UNI[code];
                map_next.bin_total  = TOT_UNI;
            end
            STYLE_ROT:
            begin
                map_next.mapped_bin = LUT_ROT[code];
                map_next.bin_total  = TOT_ROT;
            end
            default:
            begin
                map_next.mapped_bin = LUT_RIU2[code];
                map_next.bin_total  = TOT_RIU2;
            end
        endcase
    end

    assign code_ready = !valid_reg || map_ready;
    assign load       = code_valid && code_ready;
    assign map_valid  = valid_reg;
    assign map_data   = map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (code_ready)
            valid_reg <= code_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            map_reg <= map_next;
    end

endmodule
